>>> hdl/ippf_pkg.sv
// Shared types, constants and kernel tables of the projection profile filter.
// Used by ippf_sum_bank, ippf_ctrl and image_projection_profile_filter.
package ippf_pkg;

  // Default frame limits (top-level parameter defaults)
  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 1024;

  // Kernel lengths
  localparam int unsigned COL_TAPS = 6;
  localparam int unsigned ROW_TAPS = 9;

  // Field widths
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned IDX_W   = 11;
  localparam int unsigned SIZE_W  = 11;
  localparam int unsigned SUM_W   = 18;
  localparam int unsigned VALUE_W = 23;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned TAP_W   = $clog2(ROW_TAPS);
  localparam int unsigned WT_W    = 2;

  // Stream packing, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = ((PIX_W + 2 * IDX_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((VALUE_W + 7) / 8) * 8;

  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [VALUE_W-1:0] value_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR    = 3'd0,
    ACT_PIXEL    = 3'd1,
    ACT_READ_COL = 3'd2,
    ACT_READ_ROW = 3'd3,
    ACT_READ_MAP = 3'd4
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_RMW,
    S_CONV,
    S_DRAIN,
    S_DONE
  } state_e;

  typedef enum logic {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

  // Request to one sum bank: read (optionally followed by a saturating update), or clear
  typedef struct packed {
    logic rd;
    logic upd;
    logic clr;
  } bank_req_t;

  function automatic int unsigned max_int(input int unsigned a, input int unsigned b);
    return (a > b) ? a : b;
  endfunction

  // Column kernel {1,3,1,1,3,1}
  function automatic logic [WT_W-1:0] col_weight(input logic [TAP_W-1:0] j);
    logic [WT_W-1:0] w;
    unique case (j)
      4'd0, 4'd2, 4'd3, 4'd5: w = 2'd1;
      4'd1, 4'd4:             w = 2'd3;
      default:                w = 2'd0;
    endcase
    return w;
  endfunction

  // Row kernel {1,3,1,0,0,0,1,3,1}
  function automatic logic [WT_W-1:0] row_weight(input logic [TAP_W-1:0] j);
    logic [WT_W-1:0] w;
    unique case (j)
      4'd0, 4'd2, 4'd6, 4'd8: w = 2'd1;
      4'd1, 4'd7:             w = 2'd3;
      default:                w = 2'd0;
    endcase
    return w;
  endfunction

endpackage

>>> hdl/ippf_sum_bank.sv
// One profile sum memory with registered read and saturating read-modify-write.
// Depends on ippf_pkg (sum_t, bank_req_t).
module ippf_sum_bank #(
  parameter int unsigned  DEPTH = ippf_pkg::MAX_WIDTH_DEF,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ippf_pkg::bank_req_t        req_i,
  input  logic [AW-1:0]              addr_i,
  input  logic [ippf_pkg::PIX_W-1:0] pixel_i,
  output ippf_pkg::sum_t             rd_data_o
);
  import ippf_pkg::*;

  sum_t             mem [DEPTH];
  sum_t             rd_data_q;
  logic             upd_q;
  logic [AW-1:0]    upd_addr_q;
  logic [PIX_W-1:0] upd_pix_q;
  logic [SUM_W:0]   sum_raw;
  sum_t             sum_sat;
  logic             clr_hit;

  // Saturating add of the pending pixel onto the read data
  assign sum_raw = {1'b0, rd_data_q} + (SUM_W+1)'(upd_pix_q);
  assign sum_sat = sum_raw[SUM_W] ? '1 : sum_raw[SUM_W-1:0];
  assign clr_hit = ({1'b0, addr_i} < (AW+1)'(DEPTH));

  // Update pending flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upd_q <= 1'b0;
    end else begin
      upd_q <= req_i.rd & req_i.upd;
    end
  end

  // Memory: one read port, one write port
  always_ff @(posedge clk_i) begin
    if (req_i.rd) begin
      rd_data_q  <= mem[addr_i];
      upd_addr_q <= addr_i;
      upd_pix_q  <= pixel_i;
    end
    if (req_i.clr) begin
      if (clr_hit) begin
        mem[addr_i] <= '0;
      end
    end else if (upd_q) begin
      mem[upd_addr_q] <= sum_sat;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hdl/ippf_ctrl.sv
// Sequencer: raster position, clearing sweep, pixel update and convolution walk.
// Depends on ippf_pkg; drives the two ippf_sum_bank instances.
module ippf_ctrl #(
  parameter int unsigned  MAX_WIDTH  = ippf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned  MAX_HEIGHT = ippf_pkg::MAX_HEIGHT_DEF,
  localparam int unsigned CA_W       = $clog2(MAX_WIDTH),
  localparam int unsigned RA_W       = $clog2(MAX_HEIGHT)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // item side
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ippf_pkg::ACT_W-1:0]  action_i,
  input  logic [ippf_pkg::IDX_W-1:0]  col_index_i,
  input  logic [ippf_pkg::IDX_W-1:0]  row_index_i,
  input  logic [ippf_pkg::SIZE_W-1:0] cfg_width_i,
  input  logic [ippf_pkg::SIZE_W-1:0] cfg_height_i,
  // result side
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output ippf_pkg::value_t            res_value_o,
  output logic [ippf_pkg::STAT_W-1:0] res_status_o,
  // bank side
  output ippf_pkg::bank_req_t         col_req_o,
  output logic [CA_W-1:0]             col_addr_o,
  input  ippf_pkg::sum_t              col_data_i,
  output ippf_pkg::bank_req_t         row_req_o,
  output logic [RA_W-1:0]             row_addr_o,
  input  ippf_pkg::sum_t              row_data_i
);
  import ippf_pkg::*;

  localparam int unsigned CLR_DEPTH = max_int(MAX_WIDTH, MAX_HEIGHT);
  localparam int unsigned CLR_W     = $clog2(CLR_DEPTH);
  localparam int unsigned EW        = max_int(max_int($clog2(MAX_WIDTH + 1),
                                                      $clog2(MAX_HEIGHT + 1)),
                                              max_int(IDX_W, SIZE_W)) + 1;
  localparam int unsigned TERM_W    = SUM_W + 2;

  state_e              state_q, state_d;
  logic [CLR_W-1:0]    clr_cnt_q, clr_cnt_d;
  logic [CA_W-1:0]     col_q, col_d;
  logic [RA_W:0]       row_q, row_d;
  logic [TAP_W-1:0]    step_q, step_d;
  logic                use_col_q, use_col_d, use_row_q, use_row_d;
  logic [EW-1:0]       n_col_q, n_col_d, n_row_q, n_row_d;
  logic                tcol_v_q, tcol_v_d, trow_v_q, trow_v_d;
  logic [WT_W-1:0]     tcol_w_q, tcol_w_d, trow_w_q, trow_w_d;
  value_t              acc_q, acc_d;
  value_t              res_value_q, res_value_d;
  status_e             res_status_q, res_status_d;

  action_e             act;
  logic                accept;
  logic [EW-1:0]       w_e, h_e, col_len, row_len;
  logic                wrap_pre, frame_full, col_last, col_oor, row_oor;
  logic [CA_W-1:0]     pos_col;
  logic [RA_W:0]       pos_row;
  logic [EW-1:0]       j_e, k_col, k_row;
  logic [WT_W-1:0]     cw, rw;
  logic                col_tap_v, row_tap_v;
  logic [TERM_W-1:0]   col_term, row_term;
  logic                clr_last;

  function automatic logic [TERM_W-1:0] scale(input sum_t d, input logic [WT_W-1:0] w);
    logic [TERM_W-1:0] r;
    r = (w == 2'd3) ? ({2'b00, d} + {1'b0, d, 1'b0}) : {2'b00, d};
    return r;
  endfunction

  assign act    = action_e'(action_i);
  assign accept = in_valid_i && in_ready_o;

  // Effective frame size: zero acts as one, above the limit acts as the limit
  assign w_e = (cfg_width_i == '0) ? EW'(1) :
               (EW'(cfg_width_i) > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(cfg_width_i);
  assign h_e = (cfg_height_i == '0) ? EW'(1) :
               (EW'(cfg_height_i) > EW'(MAX_HEIGHT)) ? EW'(MAX_HEIGHT) : EW'(cfg_height_i);
  assign col_len = w_e + EW'(COL_TAPS - 1);
  assign row_len = h_e + EW'(ROW_TAPS - 1);
  assign col_oor = (EW'(col_index_i) >= col_len);
  assign row_oor = (EW'(row_index_i) >= row_len);

  // Raster position; a shrunk width moves on to the next row first
  assign wrap_pre   = (EW'(row_q) < h_e) && (EW'(col_q) >= w_e);
  assign pos_col    = wrap_pre ? '0 : col_q;
  assign pos_row    = wrap_pre ? row_q + 1'b1 : row_q;
  assign frame_full = (EW'(pos_row) >= h_e);
  assign col_last   = ((EW'(pos_col) + EW'(1)) >= w_e);

  // Current convolution tap: sample n - j of each profile
  assign j_e       = EW'(step_q);
  assign k_col     = n_col_q - j_e;
  assign k_row     = n_row_q - j_e;
  assign cw        = col_weight(step_q);
  assign rw        = row_weight(step_q);
  assign col_tap_v = use_col_q && (n_col_q >= j_e) && (k_col < w_e) && (cw != '0);
  assign row_tap_v = use_row_q && (n_row_q >= j_e) && (k_row < h_e) && (rw != '0);

  // Weighted read data of the previous tap
  assign col_term = tcol_v_q ? scale(col_data_i, tcol_w_q) : '0;
  assign row_term = trow_v_q ? scale(row_data_i, trow_w_q) : '0;

  assign clr_last = (clr_cnt_q == CLR_W'(CLR_DEPTH - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT: begin
        if (clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (act)
            ACT_CLEAR:    state_d = S_CLEAR;
            ACT_PIXEL:    state_d = frame_full ? S_DONE : S_RMW;
            ACT_READ_COL: state_d = col_oor ? S_DONE : S_CONV;
            ACT_READ_ROW: state_d = row_oor ? S_DONE : S_CONV;
            ACT_READ_MAP: state_d = (col_oor || row_oor) ? S_DONE : S_CONV;
            default:      state_d = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        if (clr_last) state_d = S_DONE;
      end
      S_RMW:   state_d = S_DONE;
      S_CONV: begin
        if (step_q == TAP_W'(ROW_TAPS - 1)) state_d = S_DRAIN;
      end
      S_DRAIN: state_d = S_DONE;
      S_DONE: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_INIT;
    endcase
  end

  // Handshake and bank requests
  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    res_valid_o = (state_q == S_DONE);
    col_req_o   = '0;
    row_req_o   = '0;
    col_addr_o  = pos_col;
    row_addr_o  = pos_row[RA_W-1:0];
    unique case (state_q)
      S_INIT, S_CLEAR: begin
        col_req_o.clr = 1'b1;
        row_req_o.clr = 1'b1;
        col_addr_o    = clr_cnt_q[CA_W-1:0];
        row_addr_o    = clr_cnt_q[RA_W-1:0];
      end
      S_IDLE: begin
        if (in_valid_i && (act == ACT_PIXEL) && !frame_full) begin
          col_req_o.rd  = 1'b1;
          col_req_o.upd = 1'b1;
          row_req_o.rd  = 1'b1;
          row_req_o.upd = 1'b1;
        end
      end
      S_CONV: begin
        col_req_o.rd = col_tap_v;
        row_req_o.rd = row_tap_v;
        col_addr_o   = k_col[CA_W-1:0];
        row_addr_o   = k_row[RA_W-1:0];
      end
      default: ;
    endcase
  end

  // Datapath next values
  always_comb begin
    clr_cnt_d    = clr_cnt_q;
    col_d        = col_q;
    row_d        = row_q;
    step_d       = step_q;
    use_col_d    = use_col_q;
    use_row_d    = use_row_q;
    n_col_d      = n_col_q;
    n_row_d      = n_row_q;
    tcol_v_d     = 1'b0;
    trow_v_d     = 1'b0;
    tcol_w_d     = cw;
    trow_w_d     = rw;
    acc_d        = acc_q + VALUE_W'(col_term) + VALUE_W'(row_term);
    res_value_d  = res_value_q;
    res_status_d = res_status_q;

    unique case (state_q)
      S_INIT, S_CLEAR: clr_cnt_d = clr_cnt_q + 1'b1;
      S_IDLE: begin
        if (accept) begin
          acc_d        = '0;
          step_d       = '0;
          n_col_d      = EW'(col_index_i);
          n_row_d      = EW'(row_index_i);
          use_col_d    = (act == ACT_READ_COL) || (act == ACT_READ_MAP);
          use_row_d    = (act == ACT_READ_ROW) || (act == ACT_READ_MAP);
          res_value_d  = '0;
          res_status_d = STAT_OK;
          unique case (act)
            ACT_CLEAR: begin
              clr_cnt_d = '0;
              col_d     = '0;
              row_d     = '0;
            end
            ACT_PIXEL: begin
              if (frame_full) begin
                // dropped pixel still keeps the move to the next row
                res_status_d = STAT_FULL;
                col_d        = pos_col;
                row_d        = pos_row;
              end else begin
                col_d = col_last ? '0 : pos_col + 1'b1;
                row_d = col_last ? pos_row + 1'b1 : pos_row;
              end
            end
            ACT_READ_COL: if (col_oor) res_status_d = STAT_RANGE;
            ACT_READ_ROW: if (row_oor) res_status_d = STAT_RANGE;
            ACT_READ_MAP: if (col_oor || row_oor) res_status_d = STAT_RANGE;
            default: ;
          endcase
        end
      end
      S_CONV: begin
        step_d   = step_q + 1'b1;
        tcol_v_d = col_tap_v;
        trow_v_d = row_tap_v;
      end
      S_DRAIN: res_value_d = acc_d;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      clr_cnt_q <= '0;
      col_q     <= '0;
      row_q     <= '0;
      step_q    <= '0;
      use_col_q <= 1'b0;
      use_row_q <= 1'b0;
      tcol_v_q  <= 1'b0;
      trow_v_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      col_q     <= col_d;
      row_q     <= row_d;
      step_q    <= step_d;
      use_col_q <= use_col_d;
      use_row_q <= use_row_d;
      tcol_v_q  <= tcol_v_d;
      trow_v_q  <= trow_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    n_col_q      <= n_col_d;
    n_row_q      <= n_row_d;
    tcol_w_q     <= tcol_w_d;
    trow_w_q     <= trow_w_d;
    acc_q        <= acc_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
  end

  assign res_value_o  = res_value_q;
  assign res_status_o = res_status_q;

  // A bank is never cleared and read in the same cycle
  a_no_clr_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((col_req_o.clr && col_req_o.rd) || (row_req_o.clr && row_req_o.rd)))
    else $error("bank clear overlaps a read");

  // Every bank update is followed by the write-back cycle
  a_rmw_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_req_o.upd && col_req_o.rd) |=> (state_q == S_RMW))
    else $error("pixel update not followed by write-back");

  // Row position never passes the frame limit
  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (EW'(row_q) <= EW'(MAX_HEIGHT)))
    else $error("row position beyond frame limit");

  // A waiting result keeps its value
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_ready_i) |=>
      (res_valid_o && $stable(res_value_q) && $stable(res_status_q)))
    else $error("pending result changed");

  // Taps only read while walking the kernel
  a_tap_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tcol_v_q || trow_v_q) |-> ((state_q == S_CONV) || (state_q == S_DRAIN)))
    else $error("tap data outside convolution walk");

endmodule

>>> hdl/image_projection_profile_filter.sv
// Top level of the projection profile filter: stream ports, size registers,
// output register. Depends on ippf_pkg, ippf_sum_bank and ippf_ctrl.
//
// Usage: items enter on the s_axis channel (tuser = action, tdata = pixel,
// col_index, row_index) and each item gives one result on m_axis (tdata =
// value, tuser = status). The cfg channel writes image_width (index 0) and
// image_height (index 1); it is always ready, and the user must write it only
// while idle; the block itself does not enforce this. Column and row sums
// live in two single-port-read memories; every item is handled alone by a
// sequencer around those memories. Per item: a pixel has its sums read, then
// a saturating write-back, then its result; a filtered read or map read walks
// the nine-step kernel, reading one tap per memory per cycle, then adds the
// last registered read; an out-of-range read, a dropped pixel or an unused
// action goes straight to its result; a clear zeroes one memory entry per
// cycle over max(MAX_WIDTH, MAX_HEIGHT) entries. After reset the same clearing
// pass runs with s_axis_tready low; configuration writes are taken meanwhile.
// A result waits in the output register while m_axis_tready is low; the next
// item is still accepted and worked on, and holds its result until the
// register frees up.
module image_projection_profile_filter #(
  parameter int unsigned MAX_WIDTH  = ippf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = ippf_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input items
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [ippf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // pixel, col_index, row_index, pad
  input  logic [ippf_pkg::ACT_W-1:0]       s_axis_tuser,  // action
  // results
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [ippf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // value, pad
  output logic [ippf_pkg::STAT_W-1:0]      m_axis_tuser,  // status
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_index_i,
  input  logic [ippf_pkg::SIZE_W-1:0]      cfg_data_i
);
  import ippf_pkg::*;

  localparam int unsigned CA_W = $clog2(MAX_WIDTH);
  localparam int unsigned RA_W = $clog2(MAX_HEIGHT);

  logic [SIZE_W-1:0] width_q, height_q;
  logic              out_valid_q;
  value_t            out_value_q;
  logic [STAT_W-1:0] out_status_q;

  logic              res_valid, res_ready;
  value_t            res_value;
  logic [STAT_W-1:0] res_status;
  bank_req_t         col_req, row_req;
  logic [CA_W-1:0]   col_addr;
  logic [RA_W-1:0]   row_addr;
  sum_t              col_data, row_data;
  logic [PIX_W-1:0]  pixel;

  assign pixel = s_axis_tdata[PIX_W-1:0];

  // Size registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_W'(1);
      height_q <= SIZE_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ippf_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .action_i     (s_axis_tuser),
    .col_index_i  (s_axis_tdata[PIX_W +: IDX_W]),
    .row_index_i  (s_axis_tdata[PIX_W + IDX_W +: IDX_W]),
    .cfg_width_i  (width_q),
    .cfg_height_i (height_q),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_value_o  (res_value),
    .res_status_o (res_status),
    .col_req_o    (col_req),
    .col_addr_o   (col_addr),
    .col_data_i   (col_data),
    .row_req_o    (row_req),
    .row_addr_o   (row_addr),
    .row_data_i   (row_data)
  );

  ippf_sum_bank #(
    .DEPTH (MAX_WIDTH)
  ) u_col_bank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (col_req),
    .addr_i    (col_addr),
    .pixel_i   (pixel),
    .rd_data_o (col_data)
  );

  ippf_sum_bank #(
    .DEPTH (MAX_HEIGHT)
  ) u_row_bank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (row_req),
    .addr_i    (row_addr),
    .pixel_i   (pixel),
    .rd_data_o (row_data)
  );

  // Output register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_value_q  <= res_value;
      out_status_q <= res_status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_value_q);
  assign m_axis_tuser  = out_status_q;

endmodule
